FILE: design/bbod_pkg.sv
package bbod_pkg;

  // Frame store geometry and outline thickness
  localparam int MAX_WIDTH      = 256;
  localparam int MAX_HEIGHT     = 256;
  localparam int LINE_THICKNESS = 2;

  localparam int X_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Y_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int P_W    = (X_W > Y_W) ? X_W : Y_W;
  localparam int T_W    = (LINE_THICKNESS > 1) ? $clog2(LINE_THICKNESS) : 1;
  localparam int AW_W   = $clog2(MAX_WIDTH + 1);
  localparam int AH_W   = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int ID_W    = 32;
  localparam int COORD_W = 16;
  localparam int READ_W  = 8;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 4 * CHAN_W;

  // Configuration port
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     FRAME_RESET      = 9'd256;

  // Commands
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  // Color hash
  localparam logic [ID_W-1:0]   HASH_MULT   = 32'd2654435761;
  localparam logic [CHAN_W-1:0] CHAN_FLOOR  = 8'd50;
  localparam logic [CHAN_W-1:0] ALPHA_DRAWN = 8'd255;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic seg_load;
    logic edge_adv;
    logic pix_wr;
    logic rd_issue;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic seg_empty;
    logic run_end;
    logic edge_last;
  } stat_t;

endpackage

FILE: design/bbod_req_if.sv
interface bbod_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [bbod_pkg::CMD_W-1:0]           cmd;
  logic [bbod_pkg::ID_W-1:0]            blob_id;
  logic signed [bbod_pkg::COORD_W-1:0]  box_left;
  logic signed [bbod_pkg::COORD_W-1:0]  box_right;
  logic signed [bbod_pkg::COORD_W-1:0]  box_top;
  logic signed [bbod_pkg::COORD_W-1:0]  box_bottom;
  logic [bbod_pkg::READ_W-1:0]          read_x;
  logic [bbod_pkg::READ_W-1:0]          read_y;

  modport source (output valid, cmd, blob_id, box_left, box_right, box_top, box_bottom,
                  read_x, read_y, input ready);
  modport sink (input valid, cmd, blob_id, box_left, box_right, box_top, box_bottom,
                read_x, read_y, output ready);
endinterface

FILE: design/bbod_rsp_if.sv
interface bbod_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bbod_pkg::CHAN_W-1:0]   pixel_red;
  logic [bbod_pkg::CHAN_W-1:0]   pixel_green;
  logic [bbod_pkg::CHAN_W-1:0]   pixel_blue;
  logic [bbod_pkg::CHAN_W-1:0]   pixel_alpha;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
                  input ready);
  modport sink (input valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
                output ready);
endinterface

FILE: design/bbod_ctrl.sv
module bbod_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bbod_pkg::CMD_W-1:0] in_cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bbod_pkg::ctrl_t            ctrl,
  input  bbod_pkg::stat_t            stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_SEG   = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          unique case (in_cmd)
            bbod_pkg::CMD_CLEAR: state_next = S_CLEAR;
            bbod_pkg::CMD_DRAW:  state_next = S_SEG;
            bbod_pkg::CMD_READ:  state_next = S_RD;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        ctrl.clr_wr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_SEG: begin
        // skip an edge with an empty run, else start its run
        if (stat.seg_empty) begin
          ctrl.edge_adv = 1'b1;
          if (stat.edge_last) state_next = S_IDLE;
        end else begin
          ctrl.seg_load = 1'b1;
          state_next    = S_RUN;
        end
      end
      S_RUN: begin
        ctrl.pix_wr = 1'b1;
        if (stat.run_end) begin
          ctrl.edge_adv = 1'b1;
          state_next    = stat.edge_last ? S_IDLE : S_SEG;
        end
      end
      S_RD: begin
        ctrl.rd_issue = 1'b1;
        state_next    = S_RESP;
      end
      S_RESP: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          ctrl.out_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = ctrl.out_load || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: design/bbod_dp.sv
module bbod_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [bbod_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bbod_pkg::CFG_W-1:0]           cfg_wr_data,
  input  logic [bbod_pkg::ID_W-1:0]            blob_id,
  input  logic signed [bbod_pkg::COORD_W-1:0]  box_left,
  input  logic signed [bbod_pkg::COORD_W-1:0]  box_right,
  input  logic signed [bbod_pkg::COORD_W-1:0]  box_top,
  input  logic signed [bbod_pkg::COORD_W-1:0]  box_bottom,
  input  logic [bbod_pkg::READ_W-1:0]          read_x,
  input  logic [bbod_pkg::READ_W-1:0]          read_y,
  output logic [bbod_pkg::CHAN_W-1:0]          pixel_red,
  output logic [bbod_pkg::CHAN_W-1:0]          pixel_green,
  output logic [bbod_pkg::CHAN_W-1:0]          pixel_blue,
  output logic [bbod_pkg::CHAN_W-1:0]          pixel_alpha,
  input  bbod_pkg::ctrl_t                      ctrl,
  output bbod_pkg::stat_t                      stat
);

  localparam int X_W    = bbod_pkg::X_W;
  localparam int Y_W    = bbod_pkg::Y_W;
  localparam int P_W    = bbod_pkg::P_W;
  localparam int T_W    = bbod_pkg::T_W;
  localparam int ADDR_W = bbod_pkg::ADDR_W;
  localparam int XS_W   = ((X_W > T_W) ? X_W : T_W) + 1;
  localparam int YS_W   = ((Y_W > T_W) ? Y_W : T_W) + 1;
  localparam int ID_W_L = bbod_pkg::ID_W;

  localparam logic [1:0] EDGE_TOP    = 2'd0;
  localparam logic [1:0] EDGE_BOTTOM = 2'd1;
  localparam logic [1:0] EDGE_LEFT   = 2'd2;
  localparam logic [1:0] EDGE_RIGHT  = 2'd3;

  function automatic logic [P_W-1:0] clamp_coord(logic signed [bbod_pkg::COORD_W-1:0] v,
                                                 logic [P_W-1:0] m1);
    if (v[bbod_pkg::COORD_W-1]) return '0;
    else if (15'(v[bbod_pkg::COORD_W-2:0]) > 15'(m1)) return m1;
    else return P_W'(v[bbod_pkg::COORD_W-2:0]);
  endfunction

  // configuration
  logic [bbod_pkg::CFG_W-1:0] frame_width;
  logic [bbod_pkg::CFG_W-1:0] frame_height;
  logic [bbod_pkg::AW_W-1:0]  act_w;
  logic [bbod_pkg::AH_W-1:0]  act_h;
  logic [X_W-1:0]             w_m1;
  logic [Y_W-1:0]             h_m1;

  // draw state
  logic [X_W-1:0]    x0, x1;
  logic [Y_W-1:0]    y0, y1;
  logic [T_W-1:0]    pass_t;
  logic [1:0]        edge_sel;
  logic [P_W-1:0]    pos;
  logic [ID_W_L-1:0] id_q;
  logic [31:0]       hash_q;
  logic [bbod_pkg::PIX_W-1:0] color;
  logic [bbod_pkg::CHAN_W-1:0] ch_r, ch_g, ch_b;

  // read / clear state
  logic [ADDR_W-1:0]          clr_ptr;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       rd_in;
  logic [bbod_pkg::PIX_W-1:0] rd_data;

  // pass geometry
  logic [YS_W-1:0] y0t;
  logic [XS_W-1:0] x0t;
  logic [Y_W-1:0]  row_a, row_b;
  logic [X_W-1:0]  col_a, col_b;
  logic            is_row;
  logic [X_W-1:0]  fix_x;
  logic [Y_W-1:0]  fix_y;
  logic [P_W-1:0]  run_lo, run_hi;
  logic [X_W-1:0]  px;
  logic [Y_W-1:0]  py;

  // write port
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  logic [bbod_pkg::PIX_W-1:0] wr_data;

  logic [bbod_pkg::PIX_W-1:0] mem [bbod_pkg::DEPTH];

  always_comb begin
    if (frame_width == '0) act_w = bbod_pkg::AW_W'(1);
    else if (int'(frame_width) > bbod_pkg::MAX_WIDTH)
      act_w = bbod_pkg::AW_W'(bbod_pkg::MAX_WIDTH);
    else act_w = bbod_pkg::AW_W'(frame_width);
    if (frame_height == '0) act_h = bbod_pkg::AH_W'(1);
    else if (int'(frame_height) > bbod_pkg::MAX_HEIGHT)
      act_h = bbod_pkg::AH_W'(bbod_pkg::MAX_HEIGHT);
    else act_h = bbod_pkg::AH_W'(frame_height);
  end

  assign w_m1 = X_W'(act_w - 1'b1);
  assign h_m1 = Y_W'(act_h - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bbod_pkg::FRAME_RESET;
      frame_height <= bbod_pkg::FRAME_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bbod_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_wr_data;
        bbod_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // inner edges of the current pass, pulled back into the frame
  always_comb begin
    y0t   = YS_W'(y0) + YS_W'(pass_t);
    x0t   = XS_W'(x0) + XS_W'(pass_t);
    row_a = (y0t > YS_W'(h_m1)) ? h_m1 : Y_W'(y0t);
    col_a = (x0t > XS_W'(w_m1)) ? w_m1 : X_W'(x0t);
    row_b = (YS_W'(y1) < YS_W'(pass_t)) ? '0 : Y_W'(YS_W'(y1) - YS_W'(pass_t));
    col_b = (XS_W'(x1) < XS_W'(pass_t)) ? '0 : X_W'(XS_W'(x1) - XS_W'(pass_t));
  end

  always_comb begin
    is_row = 1'b1;
    fix_x  = col_a;
    fix_y  = row_a;
    run_lo = P_W'(x0);
    run_hi = P_W'(x1);
    case (edge_sel)
      EDGE_TOP: begin
        fix_y = row_a;
      end
      EDGE_BOTTOM: begin
        fix_y = row_b;
      end
      EDGE_LEFT: begin
        is_row = 1'b0;
        fix_x  = col_a;
        run_lo = P_W'(y0);
        run_hi = P_W'(y1);
      end
      default: begin
        is_row = 1'b0;
        fix_x  = col_b;
        run_lo = P_W'(y0);
        run_hi = P_W'(y1);
      end
    endcase
    px = is_row ? pos[X_W-1:0] : fix_x;
    py = is_row ? fix_y : pos[Y_W-1:0];
  end

  assign stat.seg_empty = run_lo > run_hi;
  assign stat.run_end   = pos == run_hi;
  assign stat.edge_last = (pass_t == T_W'(bbod_pkg::LINE_THICKNESS - 1)) &&
                          (edge_sel == EDGE_RIGHT);
  assign stat.clr_last  = clr_ptr == ADDR_W'(bbod_pkg::DEPTH - 1);

  // outline color: floor each channel, alpha opaque
  assign ch_r  = (hash_q[7:0] < bbod_pkg::CHAN_FLOOR) ? bbod_pkg::CHAN_FLOOR : hash_q[7:0];
  assign ch_g  = (hash_q[15:8] < bbod_pkg::CHAN_FLOOR) ? bbod_pkg::CHAN_FLOOR : hash_q[15:8];
  assign ch_b  = (hash_q[23:16] < bbod_pkg::CHAN_FLOOR) ? bbod_pkg::CHAN_FLOOR : hash_q[23:16];
  assign color = {bbod_pkg::ALPHA_DRAWN, ch_b, ch_g, ch_r};

  always_ff @(posedge clk) begin
    hash_q <= id_q * bbod_pkg::HASH_MULT;
    if (ctrl.load) begin
      id_q     <= blob_id;
      x0       <= X_W'(clamp_coord(box_left, P_W'(w_m1)));
      x1       <= X_W'(clamp_coord(box_right, P_W'(w_m1)));
      y0       <= Y_W'(clamp_coord(box_top, P_W'(h_m1)));
      y1       <= Y_W'(clamp_coord(box_bottom, P_W'(h_m1)));
      pass_t   <= '0;
      edge_sel <= EDGE_TOP;
      clr_ptr  <= '0;
      rd_in    <= (int'(read_x) < int'(act_w)) && (int'(read_y) < int'(act_h));
      rd_addr  <= ADDR_W'(Y_W'(read_y)) * ADDR_W'(bbod_pkg::MAX_WIDTH) +
                  ADDR_W'(X_W'(read_x));
    end
    if (ctrl.clr_wr) clr_ptr <= clr_ptr + 1'b1;
    if (ctrl.seg_load) pos <= run_lo;
    if (ctrl.pix_wr) pos <= pos + 1'b1;
    if (ctrl.edge_adv) begin
      edge_sel <= edge_sel + 1'b1;
      if (edge_sel == EDGE_RIGHT) pass_t <= pass_t + 1'b1;
    end
  end

  assign wr_en   = ctrl.clr_wr || ctrl.pix_wr;
  assign wr_addr = ctrl.clr_wr ? clr_ptr :
                   ADDR_W'(py) * ADDR_W'(bbod_pkg::MAX_WIDTH) + ADDR_W'(px);
  assign wr_data = ctrl.clr_wr ? '0 : color;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_issue) rd_data <= mem[rd_addr];
  end

  // output register; pixels outside the active frame read as zero
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      pixel_red   <= rd_in ? rd_data[7:0]   : '0;
      pixel_green <= rd_in ? rd_data[15:8]  : '0;
      pixel_blue  <= rd_in ? rd_data[23:16] : '0;
      pixel_alpha <= rd_in ? rd_data[31:24] : '0;
    end
  end

endmodule

FILE: design/blob_box_outline_drawer.sv
// Channel  Role  Word
// req      sink  cmd, blob_id, box_left/right/top/bottom, read_x, read_y
// rsp      src   pixel_red, pixel_green, pixel_blue, pixel_alpha (reads only)
// cfg      write frame_width (index 0), frame_height (index 1)
//
// One word at a time; each is accepted in idle, then: clear writes all
// MAX_WIDTH*MAX_HEIGHT words (65536) of the store, one word a cycle; draw takes a
// setup step per edge, then writes that edge's run one pixel a cycle; read goes
// through the registered store port, then loads its word into the rsp register.
// Reset (rst, synchronous) returns to idle and sets both frame sizes to 256;
// the frame store holds garbage until the first clear.
// A stalled rsp holds its word; req keeps accepting clears and draws meanwhile,
// and a later read waits in its last step until the rsp register frees up.
module blob_box_outline_drawer (
  input  logic                             clk,
  input  logic                             rst,
  bbod_req_if.sink                         req,
  bbod_rsp_if.source                       rsp,
  input  logic                             cfg_wr_en,
  input  logic [bbod_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbod_pkg::CFG_W-1:0]       cfg_wr_data
);

  bbod_pkg::ctrl_t ctrl;
  bbod_pkg::stat_t stat;

  // sequencer: accept, walk clear / outline edges, issue reads
  bbod_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_cmd    (req.cmd),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  // box clamp, color hash, edge counters, frame store and rsp register
  bbod_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .blob_id     (req.blob_id),
    .box_left    (req.box_left),
    .box_right   (req.box_right),
    .box_top     (req.box_top),
    .box_bottom  (req.box_bottom),
    .read_x      (req.read_x),
    .read_y      (req.read_y),
    .pixel_red   (rsp.pixel_red),
    .pixel_green (rsp.pixel_green),
    .pixel_blue  (rsp.pixel_blue),
    .pixel_alpha (rsp.pixel_alpha),
    .ctrl        (ctrl),
    .stat        (stat)
  );

`ifndef ASSERT_OFF
  // never overwrite a word still waiting on rsp
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> (!rsp.valid || rsp.ready))
    else $error("rsp register loaded while holding a word");

  // a read accepted while the rsp register is empty reaches rsp without stalling
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.cmd == bbod_pkg::CMD_READ && !rsp.valid)
      |-> ##3 rsp.valid)
    else $error("read word did not arrive on time");

  // any real command leaves the block busy in the cycle after it
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.cmd != bbod_pkg::CMD_NONE) |=> !req.ready)
    else $error("req ready right after a command");
`endif

endmodule

FILE: tb/sv/blob_box_outline_drawer_test.sv
module blob_box_outline_drawer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bbod_pkg::*;

  // One command word as it crosses the req channel
  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [ID_W-1:0]           blob_id;
    logic signed [COORD_W-1:0] box_left;
    logic signed [COORD_W-1:0] box_right;
    logic signed [COORD_W-1:0] box_top;
    logic signed [COORD_W-1:0] box_bottom;
    logic [READ_W-1:0]         read_x;
    logic [READ_W-1:0]         read_y;
  } box_cmd_t;

  // One pixel word as it leaves on the rsp channel
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

  // Settle and draw allowances cover the longest draw; a read is much shorter
  localparam int SETTLE_CYCLES  = 2100;
  localparam int CLEAR_COST     = DEPTH + 64;
  localparam int DRAW_COST      = 2100;
  localparam int GAP_ALLOWANCE  = 64;
  localparam int HOLD_CYCLES    = 600;
  localparam int RAND_PER_PHASE = 49;
  localparam int PHASES         = 5;
  localparam int PRESSURE_PHASE = 2;

  // Per-phase frame sizes (raw register values, out-of-range ones included)
  // and idle rates in percent
  localparam logic [CFG_W-1:0] PHASE_W [PHASES] = '{9'd256, 9'd0, 9'd100, 9'd511, 9'd1};
  localparam logic [CFG_W-1:0] PHASE_H [PHASES] = '{9'd256, 9'd511, 9'd37, 9'd0, 9'd170};
  localparam int PHASE_SRC_IDLE [PHASES]  = '{0, 70, 0, 10, 0};
  localparam int PHASE_SINK_IDLE [PHASES] = '{0, 0, 70, 10, 0};
  localparam bit PHASE_CLEAR [PHASES]     = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wr_data;

  bbod_req_if req_bus ();
  bbod_rsp_if rsp_bus ();

  blob_box_outline_drawer dut (
    .clk         (clk),
    .rst         (rst),
    .req         (req_bus),
    .rsp         (rsp_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  // Predictor state: our own copy of the frame store and the size registers
  logic [PIX_W-1:0] frame_mem [DEPTH];
  logic [CFG_W-1:0] frame_w_reg = FRAME_RESET;
  logic [CFG_W-1:0] frame_h_reg = FRAME_RESET;

  box_cmd_t pending_cmds [$];
  pixel_t   pixel_expect [$];

  int error_count    = 0;
  int cycle_count    = 0;
  int cycle_budget   = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  logic req_taken = 1'b0;
  logic hold_arm  = 1'b0;
  logic hold_used = 1'b0;
  int   hold_left = 0;

  // Last box handed to the generator, so reads can aim at its outline
  int lb_left = 0, lb_right = 0, lb_top = 0, lb_bottom = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
  endtask

  function automatic int clamp_to(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Zero acts as one, anything past the store edge acts as the store edge
  function automatic int active_size(input logic [CFG_W-1:0] v, input int max_size);
    if (v == 0) return 1;
    if (int'(v) > max_size) return max_size;
    return int'(v);
  endfunction

  // Multiplicative hash of the id, each channel floored, alpha opaque
  function automatic logic [PIX_W-1:0] outline_color(input logic [ID_W-1:0] id);
    logic [ID_W-1:0]   h;
    logic [CHAN_W-1:0] r, g, b;
    h = id * HASH_MULT;
    r = h[7:0];
    g = h[15:8];
    b = h[23:16];
    if (r < CHAN_FLOOR) r = CHAN_FLOOR;
    if (g < CHAN_FLOOR) g = CHAN_FLOOR;
    if (b < CHAN_FLOOR) b = CHAN_FLOOR;
    return {ALPHA_DRAWN, b, g, r};
  endfunction

  function automatic void put_pixel(input int x, input int y, input int w, input int h,
                                    input logic [PIX_W-1:0] c);
    if (x >= 0 && x < w && y >= 0 && y < h)
      frame_mem[y * MAX_WIDTH + x] = c;
  endfunction

  // Apply one accepted command to the predicted frame and queue any read result
  function automatic void rasterize_command(input box_cmd_t c);
    int w, h, x0, x1, y0, y1, ra, rb, ca, cb, t, i, rx, ry;
    logic [PIX_W-1:0] color, p;
    pixel_t px;
    w = active_size(frame_w_reg, MAX_WIDTH);
    h = active_size(frame_h_reg, MAX_HEIGHT);
    case (c.cmd)
      CMD_CLEAR: begin
        for (i = 0; i < DEPTH; i++) frame_mem[i] = '0;
      end
      CMD_DRAW: begin
        color = outline_color(c.blob_id);
        x0 = clamp_to($signed(c.box_left), 0, w - 1);
        x1 = clamp_to($signed(c.box_right), 0, w - 1);
        y0 = clamp_to($signed(c.box_top), 0, h - 1);
        y1 = clamp_to($signed(c.box_bottom), 0, h - 1);
        for (t = 0; t < LINE_THICKNESS; t++) begin
          ra = clamp_to(y0 + t, 0, h - 1);
          rb = clamp_to(y1 - t, 0, h - 1);
          ca = clamp_to(x0 + t, 0, w - 1);
          cb = clamp_to(x1 - t, 0, w - 1);
          for (i = x0; i <= x1; i++) begin
            put_pixel(i, ra, w, h, color);
            put_pixel(i, rb, w, h, color);
          end
          for (i = y0; i <= y1; i++) begin
            put_pixel(ca, i, w, h, color);
            put_pixel(cb, i, w, h, color);
          end
        end
      end
      CMD_READ: begin
        rx = int'(c.read_x);
        ry = int'(c.read_y);
        p = '0;
        if (rx < w && ry < h) p = frame_mem[ry * MAX_WIDTH + rx];
        px.red   = p[7:0];
        px.green = p[15:8];
        px.blue  = p[23:16];
        px.alpha = p[31:24];
        pixel_expect.push_back(px);
      end
      default: begin
        // unused code: dropped by the block, nothing to predict
      end
    endcase
  endfunction

  function automatic box_cmd_t make_cmd(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id,
                                        input int l, input int r, input int t, input int b,
                                        input int x, input int y);
    box_cmd_t c;
    c.cmd        = op;
    c.blob_id    = id;
    c.box_left   = COORD_W'(l);
    c.box_right  = COORD_W'(r);
    c.box_top    = COORD_W'(t);
    c.box_bottom = COORD_W'(b);
    c.read_x     = READ_W'(x);
    c.read_y     = READ_W'(y);
    return c;
  endfunction

  // Pick a coordinate on or near the last box edges, or anywhere between them (anywhere at all when hi is not above lo)
  function automatic int aim_near(input int lo, input int hi);
    case ($urandom_range(4))
      0: return clamp_to(lo, 0, 255);
      1: return clamp_to(lo + 1, 0, 255);
      2: return clamp_to(hi, 0, 255);
      3: return clamp_to(hi - 1, 0, 255);
      default: begin
        if (hi > lo) return clamp_to(lo + int'($urandom_range(hi - lo)), 0, 255);
        return int'($urandom_range(255));
      end
    endcase
  endfunction

  // Read with noisy unused fields; most aim at the outline last drawn
  function automatic box_cmd_t read_cmd();
    box_cmd_t c;
    c = make_cmd(CMD_READ, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom_range(255), $urandom_range(255));
    if ($urandom_range(9) >= 4) begin
      c.read_x = READ_W'(aim_near(lb_left, lb_right));
      c.read_y = READ_W'(aim_near(lb_top, lb_bottom));
    end
    return c;
  endfunction

  function automatic box_cmd_t random_command(input int w, input int h);
    box_cmd_t c;
    int roll, shape, sx, sy, a;
    roll = $urandom_range(99);
    if (roll < 48) return read_cmd();
    c = make_cmd(CMD_DRAW, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom_range(255), $urandom_range(255));
    if (roll < 53) c.cmd = CMD_NONE;
    if (c.cmd == CMD_DRAW) begin
      shape = $urandom_range(9);
      // shape 0 keeps the full-range noise coordinates
      if (shape != 0) begin
        sx = ($urandom_range(19) == 0) ? int'($urandom_range(w)) : int'($urandom_range(12));
        sy = ($urandom_range(19) == 0) ? int'($urandom_range(h)) : int'($urandom_range(12));
        a = $urandom_range(w + 3);
        c.box_left  = COORD_W'(a - 2);
        c.box_right = COORD_W'(a - 2 + sx);
        a = $urandom_range(h + 3);
        c.box_top    = COORD_W'(a - 2);
        c.box_bottom = COORD_W'(a - 2 + sy);
        // invert one axis now and then
        if (shape == 1) {c.box_left, c.box_right} = {c.box_right, c.box_left};
        if (shape == 2) {c.box_top, c.box_bottom} = {c.box_bottom, c.box_top};
      end
      lb_left   = $signed(c.box_left);
      lb_right  = $signed(c.box_right);
      lb_top    = $signed(c.box_top);
      lb_bottom = $signed(c.box_bottom);
    end
    return c;
  endfunction

  // Queue a word for the driver and grow the cycle budget by its worst case
  task automatic queue_item(input box_cmd_t c);
    pending_cmds.push_back(c);
    case (c.cmd)
      CMD_CLEAR: cycle_budget += CLEAR_COST;
      CMD_DRAW:  cycle_budget += DRAW_COST;
      default:   cycle_budget += 16;
    endcase
    cycle_budget += 3 * GAP_ALLOWANCE;
  endtask

  task automatic write_frame_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_FRAME_WIDTH) frame_w_reg = value;
    else frame_h_reg = value;
  endtask

  // Wait until every word went in and every read came back, then let the
  // block finish whatever draw or clear might still be running
  task automatic drain_and_settle();
    cycle_budget += SETTLE_CYCLES;
    while (pending_cmds.size() != 0 || req_bus.valid || pixel_expect.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: present a new word at the falling edge once the last one was taken
  always @(negedge clk) begin
    box_cmd_t nxt;
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_taken) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pending_cmds.pop_front();
        req_bus.valid      <= 1'b1;
        req_bus.cmd        <= nxt.cmd;
        req_bus.blob_id    <= nxt.blob_id;
        req_bus.box_left   <= nxt.box_left;
        req_bus.box_right  <= nxt.box_right;
        req_bus.box_top    <= nxt.box_top;
        req_bus.box_bottom <= nxt.box_bottom;
        req_bus.read_x     <= nxt.read_x;
        req_bus.read_y     <= nxt.read_y;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted command word
  always @(posedge clk) begin
    box_cmd_t got;
    req_taken <= !rst && req_bus.valid && req_bus.ready;
    if (!rst && req_bus.valid && req_bus.ready) begin
      got.cmd        = req_bus.cmd;
      got.blob_id    = req_bus.blob_id;
      got.box_left   = req_bus.box_left;
      got.box_right  = req_bus.box_right;
      got.box_top    = req_bus.box_top;
      got.box_bottom = req_bus.box_bottom;
      got.read_x     = req_bus.read_x;
      got.read_y     = req_bus.read_y;
      rasterize_command(got);
    end
  end

  // Long receiver hold-off, armed once; the block must fill and stall req
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_arm && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: stall at random, and throughout the hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Monitor: match every pixel word against the oldest expectation
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pixel_expect.size() == 0) begin
        report_mismatch("pixel word with nothing expected",
                        {rsp_bus.pixel_alpha, rsp_bus.pixel_blue,
                         rsp_bus.pixel_green, rsp_bus.pixel_red}, '0);
      end else begin
        want = pixel_expect.pop_front();
        if (rsp_bus.pixel_red !== want.red)
          report_mismatch("pixel_red", rsp_bus.pixel_red, want.red);
        if (rsp_bus.pixel_green !== want.green)
          report_mismatch("pixel_green", rsp_bus.pixel_green, want.green);
        if (rsp_bus.pixel_blue !== want.blue)
          report_mismatch("pixel_blue", rsp_bus.pixel_blue, want.blue);
        if (rsp_bus.pixel_alpha !== want.alpha)
          report_mismatch("pixel_alpha", rsp_bus.pixel_alpha, want.alpha);
      end
    end
  end

  // Watchdog: several times the slowest legal run of what was queued
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4 * cycle_budget + 50000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int ph, n, w, h;
    box_cmd_t c;

    // Known values on every input before the first edge
    req_bus.valid      = 1'b0;
    req_bus.cmd        = CMD_CLEAR;
    req_bus.blob_id    = '0;
    req_bus.box_left   = '0;
    req_bus.box_right  = '0;
    req_bus.box_top    = '0;
    req_bus.box_bottom = '0;
    req_bus.read_x     = '0;
    req_bus.read_y     = '0;
    rsp_bus.ready      = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_index          = REG_FRAME_WIDTH;
    cfg_wr_data        = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part on a full 256 x 256 frame. Clear first: the store holds
    // garbage until then, so nothing may read it earlier.
    write_frame_reg(REG_FRAME_WIDTH, FRAME_RESET);
    write_frame_reg(REG_FRAME_HEIGHT, FRAME_RESET);
    queue_item(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 255, 255));
    // Box far past every frame edge; id zero floors every channel
    queue_item(make_cmd(CMD_DRAW, 0, -32768, 32767, -32768, 32767, 0, 0));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 1, 1));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 2, 2));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 255, 128));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 254, 254));
    // Ordinary box with an all-ones id, overwriting nothing
    queue_item(make_cmd(CMD_DRAW, 32'hFFFF_FFFF, 10, 20, 30, 40, 0, 0));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 11, 35));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 12, 35));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 20, 40));
    // Inverted in x: no rows, but the columns still land
    queue_item(make_cmd(CMD_DRAW, 1, 50, 40, 5, 60, 0, 0));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 50, 10));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 39, 10));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 45, 5));
    // Single-pixel box: the second pass spreads it into a plus sign
    queue_item(make_cmd(CMD_DRAW, 12345, 100, 100, 100, 100, 0, 0));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 100, 101));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 101, 100));
    // Unused command code with every field busy: must be dropped silently
    queue_item(make_cmd(CMD_NONE, 32'hA5A5_A5A5, 32767, -32768, 32767, -32768, 255, 255));
    // Box straddling the left and bottom edges, top bit of the id set
    queue_item(make_cmd(CMD_DRAW, 32'h8000_0000, -5, 3, 250, 32767, 0, 0));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 250));
    queue_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 3, 254));
    drain_and_settle();

    // Random phases: new frame size, new idle pattern, then random words.
    // Each phase ends on a read so the block is known idle once it returns.
    for (ph = 0; ph < PHASES; ph++) begin
      write_frame_reg(REG_FRAME_WIDTH, PHASE_W[ph]);
      write_frame_reg(REG_FRAME_HEIGHT, PHASE_H[ph]);
      src_idle_pct   = PHASE_SRC_IDLE[ph];
      sink_stall_pct = PHASE_SINK_IDLE[ph];
      w = active_size(frame_w_reg, MAX_WIDTH);
      h = active_size(frame_h_reg, MAX_HEIGHT);
      lb_left   = 0;
      lb_right  = w - 1;
      lb_top    = 0;
      lb_bottom = h - 1;
      if (PHASE_CLEAR[ph]) queue_item(make_cmd(CMD_CLEAR, $urandom(), $urandom(), $urandom(),
                                               $urandom(), $urandom(), $urandom_range(255),
                                               $urandom_range(255)));
      n = 0;
      while (n < RAND_PER_PHASE) begin
        c = random_command(w, h);
        queue_item(c);
        if (c.cmd != CMD_NONE) n++;
      end
      queue_item(read_cmd());
      if (ph == PRESSURE_PHASE) begin
        cycle_budget += HOLD_CYCLES;
        hold_arm = 1'b1;
      end
      drain_and_settle();
    end

    if (pixel_expect.size() != 0)
      report_mismatch("pixel words never delivered", pixel_expect.size(), 0);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
